// ===== hdl/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared constants and the controller-to-datapath command type for the
// LRU page replacement core.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  // Default sizing of the recency stack.
  localparam int FRAMES_DEFAULT    = 8;
  localparam int PAGE_BITS_DEFAULT = 16;

  // Fixed field widths on the ports.
  localparam int PAGE_W      = 16;
  localparam int NFRAMES_W   = 4;
  localparam int RESIDENT_W  = 4;
  localparam int TOTAL_W     = 32;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_FIELD_W = 1 + 1 + PAGE_W + RESIDENT_W + 2 * TOTAL_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [NFRAMES_W-1:0] NUM_FRAMES_RESET = 4'd4;

  // One-cycle strobes from the controller to the datapath.
  typedef struct packed {
    logic load_page;  // capture the accepted page reference
    logic do_match;   // compare the page against every resident entry
    logic do_update;  // reorder the stack, update totals, load the result
  } cmd_t;

endpackage

// ===== hdl/lrupr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer for one page reference: capture, match, update. Owns the
// input ready and the output valid flag.
// ----------------------------------------------------------------------------
module lrupr_ctrl
  import lrupr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  output logic m_tvalid,
  input  logic m_tready,
  output cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == ST_IDLE) && !rst;
  // The result register can take a new value when empty or drained this cycle.
  assign out_free = !m_tvalid || m_tready;

  assign cmd.load_page = (state == ST_IDLE) && s_tvalid;
  assign cmd.do_match  = (state == ST_MATCH);
  assign cmd.do_update = (state == ST_UPDATE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // A new report wins over the drain of the previous one.
      if ((state == ST_UPDATE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/lrupr_datapath.sv =====
// ----------------------------------------------------------------------------
// lrupr_datapath
// Recency stack, parallel page comparators, resident count, saturating
// hit and fault totals, frame-count register and the result register.
// ----------------------------------------------------------------------------
module lrupr_datapath
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEFAULT,
  parameter int PAGE_BITS = PAGE_BITS_DEFAULT
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  logic [PAGE_W-1:0]     page,
  input  logic                  cfg_we,
  input  logic [NFRAMES_W-1:0]  cfg_data,
  output logic                  hit,
  output logic                  evicted_valid,
  output logic [PAGE_W-1:0]     evicted_page,
  output logic [RESIDENT_W-1:0] resident,
  output logic [TOTAL_W-1:0]    hit_total,
  output logic [TOTAL_W-1:0]    fault_total
);

  localparam int CW = $clog2(FRAMES + 1);
  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [NFRAMES_W-1:0] num_frames;
  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] stack [FRAMES];
  logic [CW-1:0]        rc;
  logic [TOTAL_W-1:0]   hits;
  logic [TOTAL_W-1:0]   faults;
  logic                 found_r;
  logic [IW-1:0]        where_r;

  logic                 found;
  logic [IW-1:0]        where;
  logic [CW-1:0]        lim;
  logic                 full;
  logic                 evict;
  logic [CW-1:0]        pos;
  logic [CW-1:0]        top;
  logic [CW-1:0]        rc_next;
  logic [TOTAL_W-1:0]   hits_next;
  logic [TOTAL_W-1:0]   faults_next;

  // Resident pages are always distinct, so at most one comparator fires and
  // its index can be formed by OR-ing.
  always_comb begin
    found = 1'b0;
    where = '0;
    for (int k = 0; k < FRAMES; k++) begin
      if ((CW'(k) < rc) && (stack[k] == page_r)) begin
        found = 1'b1;
        where = where | IW'(k);
      end
    end
  end

  // A frame count of zero acts as one, anything above the stack depth as full.
  always_comb begin
    if (num_frames == '0) begin
      lim = CW'(1);
    end else if (8'(num_frames) > 8'(FRAMES)) begin
      lim = CW'(FRAMES);
    end else begin
      lim = CW'(num_frames);
    end
  end

  assign full  = (rc >= lim);
  assign evict = !found_r && full;

  // Entries from pos up to top-1 take their more recent neighbor and the
  // new page lands at top.
  always_comb begin
    if (found_r) begin
      pos     = CW'(where_r);
      top     = rc - CW'(1);
      rc_next = rc;
    end else if (!full) begin
      pos     = rc;
      top     = rc;
      rc_next = rc + CW'(1);
    end else begin
      pos     = '0;
      top     = rc - CW'(1);
      rc_next = rc;
    end
  end

  assign hits_next   = (found_r && (hits != '1)) ? hits + TOTAL_W'(1) : hits;
  assign faults_next = (!found_r && (faults != '1)) ? faults + TOTAL_W'(1) : faults;

  for (genvar k = 0; k < FRAMES; k++) begin : g_entry
    logic [PAGE_BITS-1:0] up;
    if (k < FRAMES - 1) begin : g_up
      assign up = stack[k+1];
    end else begin : g_top
      assign up = stack[k];
    end

    always_ff @(posedge clk) begin
      if (cmd.do_update) begin
        if ((CW'(k) >= pos) && (CW'(k) < top)) begin
          stack[k] <= up;
        end else if (CW'(k) == top) begin
          stack[k] <= page_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= NUM_FRAMES_RESET;
      rc         <= '0;
      hits       <= '0;
      faults     <= '0;
    end else begin
      if (cfg_we) begin
        num_frames <= cfg_data;
      end
      if (cmd.do_update) begin
        rc     <= rc_next;
        hits   <= hits_next;
        faults <= faults_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_page) begin
      page_r <= PAGE_BITS'(page);
    end
    if (cmd.do_match) begin
      found_r <= found;
      where_r <= where;
    end
    if (cmd.do_update) begin
      hit           <= found_r;
      evicted_valid <= evict;
      evicted_page  <= evict ? PAGE_W'(stack[0]) : '0;
      resident      <= RESIDENT_W'(rc_next);
      hit_total     <= hits_next;
      fault_total   <= faults_next;
    end
  end

endmodule

// ===== hdl/lru_page_replacement_core.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// LRU page replacement: one page reference in, one hit/fault report out.
// ----------------------------------------------------------------------------
// Usage:
// Each transaction on the slave stream carries one page number in
// s_tdata[15:0]. For every accepted reference the master stream delivers
// exactly one report transaction: hit flag, evicted page (if any), the
// resident page count after the access and the saturating hit and fault
// totals. The recency stack keeps up to num_frames pages (clamped to 1..FRAMES), least recent at
// the bottom; a hit moves the page to the top, a miss fills a free frame or
// evicts the bottom entry.
// Each reference passes through capture, the bank of parallel comparators
// and an update step that reorders the stack and loads the result register.
// The report is valid once the update step has loaded it; a new reference
// is taken only after the previous one has left the update step.
// The result register parts the two sides: a new reference is accepted and
// matched while the previous report still waits; if the receiver stalls the
// sequencer holds in its update step until the report is taken.
// num_frames is to be written through cfg_we/cfg_data only while the core is idle; the core does not enforce this.
// Reset (rst, synchronous) empties the stack, clears the totals and sets
// num_frames to 4; the core accepts references in the next cycle.
// ----------------------------------------------------------------------------
module lru_page_replacement_core
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEFAULT,
  parameter int PAGE_BITS = PAGE_BITS_DEFAULT
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [NFRAMES_W-1:0]  cfg_data,   // num_frames
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,    // page[15:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // From bit 0 up: hit, evicted_valid, evicted_page[15:0], resident[3:0],
  // hit_total[31:0], fault_total[31:0], two zero pad bits.
  output logic [OUT_DATA_W-1:0] m_tdata
);

  cmd_t                  cmd;
  logic                  hit;
  logic                  evicted_valid;
  logic [PAGE_W-1:0]     evicted_page;
  logic [RESIDENT_W-1:0] resident;
  logic [TOTAL_W-1:0]    hit_total;
  logic [TOTAL_W-1:0]    fault_total;

  // The sequencer decides when the datapath captures, compares and updates.
  lrupr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // The datapath holds every page, count and total, plus the result register.
  lrupr_datapath #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .page          (s_tdata[PAGE_W-1:0]),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .resident      (resident),
    .hit_total     (hit_total),
    .fault_total   (fault_total)
  );

  // Fields packed from the lowest bit up, zero padding to a whole byte.
  assign m_tdata = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}}, fault_total, hit_total,
                    resident, evicted_page, evicted_valid, hit};

endmodule
